// ===== rtl/core/wicmr_pkg.sv =====
// package for the wide integer centred mod reduce block: widths, register codes, states
`default_nettype none

package wicmr_pkg;

    localparam int MOD_W   = 60;
    localparam int WORD_W  = 32;
    localparam int NB_W    = 10;
    localparam int POS_W   = 5;
    localparam int CNT_W   = 10;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_BITS = CFG_IDX_W'(1);

    localparam logic [MOD_W-1:0] MODULUS_RST    = MOD_W'(65537);
    localparam logic [NB_W-1:0]  NOISE_BITS_RST = NB_W'(128);

    typedef enum logic [2:0] {
        S_DERIVE_SHIFT,
        S_DERIVE_CENTRE,
        S_IDLE,
        S_MUL_WORD,
        S_ACC_ADD,
        S_MUL_WEIGHT,
        S_FINAL
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/wide_integer_centred_mod_reduce.sv =====
// top level: word-serial wide integer reduction mod q with centre offset, one shared mod adder
// a non-last word holds the input through the word multiply, accumulate and weight multiply
// steps; the last word goes from accumulate to the final step, which gives its residue
// a new word waits until the previous one is done; all steps share one 60-bit add/sub unit
// a modulus or noise_bits write (and reset) runs the derive pass with no words taken
// reset: synchronous active low, modulus 65537, noise_bits 128, then the derive pass
`default_nettype none

module wide_integer_centred_mod_reduce (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_word_valid,
    output logic                                 o_word_stall,
    input  wire logic [wicmr_pkg::WORD_W-1:0]    i_word,
    output logic                                 o_residue_valid,
    input  wire logic                            i_residue_stall,
    output logic [wicmr_pkg::MOD_W-1:0]          o_residue,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [wicmr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [wicmr_pkg::MOD_W-1:0]     i_cfg_data
);
    import wicmr_pkg::*;

    t_state              r_state, n_state;
    logic [MOD_W-1:0]    r_q, n_q;
    logic [NB_W-1:0]     r_nb, n_nb;
    logic                r_q_ok, n_q_ok;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_phase, n_phase;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic                r_last, n_last;
    logic                r_out_valid, n_out_valid;
    logic [MOD_W-1:0]    r_prod, n_prod;
    logic [MOD_W-1:0]    r_acc, n_acc;
    logic [MOD_W-1:0]    r_weight, n_weight;
    logic [MOD_W-1:0]    r_shift, n_shift;
    logic [MOD_W-1:0]    r_centre, n_centre;
    logic [WORD_W-1:0]   r_word, n_word;
    logic [MOD_W-1:0]    r_residue, n_residue;

    // shared modular add / sub unit
    logic [MOD_W-1:0]    u_a, u_b, u_res;
    logic                u_sub;
    logic [MOD_W:0]      u_s1, u_s2;

    logic                word_acc, cfg_wr, out_free, word_last, bit_sel;
    logic [WORD_W-1:0]   top_mask;

    always_comb begin
        u_s1 = u_sub ? ({1'b0, u_a} - {1'b0, u_b}) : ({1'b0, u_a} + {1'b0, u_b});
        u_s2 = u_sub ? (u_s1 + {1'b0, r_q}) : (u_s1 - {1'b0, r_q});
        if (u_sub) begin
            u_res = u_s1[MOD_W] ? u_s2[MOD_W-1:0] : u_s1[MOD_W-1:0];
        end else begin
            u_res = u_s2[MOD_W] ? u_s1[MOD_W-1:0] : u_s2[MOD_W-1:0];
        end
    end

    // a pending config write holds off words
    assign o_word_stall    = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready     = (r_state == S_IDLE);
    assign o_residue_valid = r_out_valid;
    assign o_residue       = r_residue;

    assign word_acc  = i_word_valid && !o_word_stall;
    assign cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign out_free  = !r_out_valid || !i_residue_stall;
    assign word_last = (r_pos == r_nb[NB_W-1:POS_W]);
    // top word keeps noise_bits mod 32 plus one bits; a shift of 32 leaves all bits
    assign top_mask  = ~({WORD_W{1'b1}} << ({1'b0, r_nb[POS_W-1:0]} + 6'd1));

    always_comb begin
        n_state     = r_state;
        n_q         = r_q;
        n_nb        = r_nb;
        n_q_ok      = r_q_ok;
        n_cnt       = r_cnt;
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_last      = r_last;
        n_out_valid = r_out_valid && i_residue_stall;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_weight    = r_weight;
        n_shift     = r_shift;
        n_centre    = r_centre;
        n_word      = r_word;
        n_residue   = r_residue;
        u_a         = r_prod;
        u_b         = r_prod;
        u_sub       = 1'b0;
        bit_sel     = 1'b0;

        case (r_state)
            S_DERIVE_SHIFT: begin
                if (!r_q_ok) begin
                    n_shift  = '0;
                    n_centre = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_prod = u_res;
                    n_cnt  = r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(WORD_W - 1)) begin
                        n_shift = u_res;
                        n_prod  = MOD_W'(1);
                        n_cnt   = '0;
                        n_state = S_DERIVE_CENTRE;
                    end
                end
            end
            S_DERIVE_CENTRE: begin
                if (r_cnt == r_nb) begin
                    n_centre = r_prod;
                    n_state  = S_IDLE;
                end else begin
                    n_prod = u_res;
                    n_cnt  = r_cnt + CNT_W'(1);
                end
            end
            S_IDLE: begin
                if (cfg_wr) begin
                    if (i_cfg_index == REG_MODULUS || i_cfg_index == REG_NOISE_BITS) begin
                        if (i_cfg_index == REG_MODULUS) begin
                            n_q    = i_cfg_data;
                            n_q_ok = |i_cfg_data[MOD_W-1:1];
                        end else begin
                            n_nb = i_cfg_data[NB_W-1:0];
                        end
                        n_acc    = '0;
                        n_pos    = '0;
                        n_weight = MOD_W'(n_q_ok);
                        n_prod   = MOD_W'(1);
                        n_cnt    = '0;
                        n_state  = S_DERIVE_SHIFT;
                    end
                end else if (word_acc) begin
                    n_last = word_last;
                    n_word = word_last ? (i_word & top_mask) : i_word;
                    n_prod  = '0;
                    n_cnt   = '0;
                    n_phase = 1'b0;
                    if (!r_q_ok) begin
                        if (word_last) begin
                            n_state = S_FINAL;
                        end else begin
                            n_pos = r_pos + POS_W'(1);
                        end
                    end else begin
                        n_state = S_MUL_WORD;
                    end
                end
            end
            S_MUL_WORD: begin
                // msb first: double, then add the weight when the bit is set
                bit_sel = r_word[5'(WORD_W - 1) - r_cnt[4:0]];
                if (r_phase) begin
                    u_b     = r_weight;
                    n_prod  = bit_sel ? u_res : r_prod;
                    n_phase = 1'b0;
                    if (r_cnt == CNT_W'(WORD_W - 1)) begin
                        n_state = S_ACC_ADD;
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end else begin
                    n_prod  = u_res;
                    n_phase = 1'b1;
                end
            end
            S_ACC_ADD: begin
                u_a     = r_acc;
                u_b     = r_prod;
                n_acc   = u_res;
                n_prod  = '0;
                n_cnt   = '0;
                n_phase = 1'b0;
                n_state = r_last ? S_FINAL : S_MUL_WEIGHT;
            end
            S_MUL_WEIGHT: begin
                bit_sel = r_shift[6'(MOD_W - 1) - r_cnt[5:0]];
                if (r_phase) begin
                    u_b     = r_weight;
                    n_prod  = bit_sel ? u_res : r_prod;
                    n_phase = 1'b0;
                    if (r_cnt == CNT_W'(MOD_W - 1)) begin
                        n_weight = bit_sel ? u_res : r_prod;
                        n_pos    = r_pos + POS_W'(1);
                        n_state  = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end else begin
                    n_prod  = u_res;
                    n_phase = 1'b1;
                end
            end
            S_FINAL: begin
                u_a   = r_acc;
                u_b   = r_centre;
                u_sub = 1'b1;
                if (out_free) begin
                    n_residue   = r_q_ok ? u_res : '0;
                    n_out_valid = 1'b1;
                    n_acc       = '0;
                    n_pos       = '0;
                    n_weight    = MOD_W'(r_q_ok);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_DERIVE_SHIFT;
            r_q         <= MODULUS_RST;
            r_nb        <= NOISE_BITS_RST;
            r_q_ok      <= 1'b1;
            r_cnt       <= '0;
            r_phase     <= 1'b0;
            r_pos       <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
            r_prod      <= MOD_W'(1);
            r_acc       <= '0;
            r_weight    <= MOD_W'(1);
        end else begin
            r_state     <= n_state;
            r_q         <= n_q;
            r_nb        <= n_nb;
            r_q_ok      <= n_q_ok;
            r_cnt       <= n_cnt;
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            r_prod      <= n_prod;
            r_acc       <= n_acc;
            r_weight    <= n_weight;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift   <= n_shift;
        r_centre  <= n_centre;
        r_word    <= n_word;
        r_residue <= n_residue;
    end

    a_out_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_FINAL)
        else $error("residue valid rose outside the final step");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid) && !r_q_ok) |-> r_residue == '0)
        else $error("degenerate modulus gave a nonzero residue");

    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_q_ok) |-> (r_acc < r_q && r_weight < r_q))
        else $error("accumulator or weight not reduced mod q");

    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC_ADD) |-> $past(r_state) == S_MUL_WORD)
        else $error("accumulate step entered without a word multiply");

endmodule

`default_nettype wire
